// ----- rtl/core/frp_pkg.sv -----
package frp_pkg;

    localparam logic [7:0] HDR_FIRST    = 8'hFE;
    localparam logic [7:0] HDR_SECOND   = 8'h0A;
    localparam logic [7:0] END_MARK     = 8'h55;
    localparam logic [7:0] FLOW_OK_MARK = 8'hF5;
    localparam logic [7:0] CONF_DEFAULT = 8'd50;

    localparam int PAYLOAD_LEN = 10;
    localparam int IDX_W       = $clog2(PAYLOAD_LEN);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_LEN - 1);

    // byte offsets inside the payload
    localparam int OFS_FLOW_X   = 0;
    localparam int OFS_FLOW_Y   = 2;
    localparam int OFS_SPAN     = 4;
    localparam int OFS_DISTANCE = 6;
    localparam int OFS_VALID    = 8;
    localparam int OFS_CONF     = 9;

    localparam int TDATA_W = 72;
    localparam int TUSER_W = 2;

    typedef enum logic [4:0] {
        PH_WAIT1 = 5'b00001,
        PH_WAIT2 = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_CHECK = 5'b01000,
        PH_END   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic               flow_good;
        logic               range_valid;
        logic        [7:0]  confidence;
        logic        [15:0] dist_mm;
        logic        [15:0] span_us;
        logic signed [15:0] flow_y;
        logic signed [15:0] flow_x;
    } t_result;

endpackage

// ----- rtl/core/frp_cfg.sv -----
module frp_cfg
    import frp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_min_confidence
);

    logic [7:0] r_min_confidence;
    logic [7:0] n_min_confidence;

    // a single register: every word address decodes to it
    always_comb begin
        n_min_confidence = r_min_confidence;
        if (psel && penable && pwrite && pready) begin
            n_min_confidence = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_confidence <= CONF_DEFAULT;
        end else begin
            r_min_confidence <= n_min_confidence;
        end
    end

    assign pready           = 1'b1;
    assign prdata           = {24'd0, r_min_confidence};
    assign o_min_confidence = r_min_confidence;

    logic unused_addr;
    assign unused_addr = ^paddr;

endmodule

// ----- rtl/core/frp_parse.sv -----
module frp_parse
    import frp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_beat,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_min_confidence,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       r_xor;
    logic [7:0]       n_xor;
    logic [7:0]       r_check;
    logic [7:0]       n_check;
    logic [7:0]       r_payload [PAYLOAD_LEN];

    logic             conf_ok;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_xor       = r_xor;
        n_check     = r_check;
        o_res_valid = 1'b0;
        if (i_beat) begin
            unique case (r_phase)
                PH_WAIT2: begin
                    if (i_byte == HDR_SECOND) begin
                        n_phase = PH_DATA;
                        n_idx   = '0;
                        n_xor   = '0;
                    end else begin
                        n_phase = PH_WAIT1;
                    end
                end
                PH_DATA: begin
                    n_xor = r_xor ^ i_byte;
                    if (r_idx >= IDX_LAST) begin
                        n_phase = PH_CHECK;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_CHECK: begin
                    n_check = i_byte;
                    n_phase = PH_END;
                end
                PH_END: begin
                    o_res_valid = (i_byte == END_MARK) && (r_check == r_xor);
                    n_phase     = PH_WAIT1;
                end
                default: begin
                    n_phase = (i_byte == HDR_FIRST) ? PH_WAIT2 : PH_WAIT1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT1;
            r_idx   <= '0;
            r_xor   <= '0;
            r_check <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_xor   <= n_xor;
            r_check <= n_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat && r_phase == PH_DATA && r_idx <= IDX_LAST) begin
            r_payload[r_idx] <= i_byte;
        end
    end

    // unpack little-endian; flow is zeroed when confidence is low
    assign conf_ok = r_payload[OFS_CONF] >= i_min_confidence;

    always_comb begin
        o_res.flow_x      = conf_ok ? {r_payload[OFS_FLOW_X+1], r_payload[OFS_FLOW_X]} : '0;
        o_res.flow_y      = conf_ok ? {r_payload[OFS_FLOW_Y+1], r_payload[OFS_FLOW_Y]} : '0;
        o_res.span_us     = {r_payload[OFS_SPAN+1], r_payload[OFS_SPAN]};
        o_res.dist_mm     = {r_payload[OFS_DISTANCE+1], r_payload[OFS_DISTANCE]};
        o_res.confidence  = r_payload[OFS_CONF];
        o_res.range_valid = conf_ok;
        o_res.flow_good   = conf_ok && (r_payload[OFS_VALID] == FLOW_OK_MARK);
    end

endmodule

// ----- rtl/core/frp_out.sv -----
module frp_out
    import frp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_m_tready,
    output logic    o_in_ready,
    output logic    o_m_tvalid,
    output t_result o_m_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    // hold a result in the skid stage while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (r_out_valid && !i_m_tready && i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_res    = r_out;

endmodule

// ----- rtl/core/flow_range_frame_parser.sv -----
// Byte-serial frame parser for an optical-flow and rangefinder sensor.
// Slave stream: one received UART byte per beat in s_axis_tdata[7:0].
// A frame is FE 0A, ten payload bytes, an XOR check byte and end byte 55.
// Master stream: one result beat per good frame, 72-bit tdata holding
// flow x, flow y, time span, distance and confidence; tuser holds the
// range-valid and flow-good flags. Flow is zeroed and both flags cleared
// when confidence is below min_confidence.
// APB port: one register, min_confidence (reset 50), at every word address.
// Throughput: one byte per cycle while s_axis_tready is high, set by the per-byte state update.
// The result for an accepted end byte is registered in the output stage, or in the skid stage.
// While the receiver stalls, the output register holds its beat and one
// further result is kept in a skid stage; s_axis_tready drops only when
// that stage is full.
// Reset clears the parser to hunting for the first header byte and
// empties the output stages; the payload bytes are not cleared.
module flow_range_frame_parser
    import frp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [15:0] flow_x, [31:16] flow_y, [47:32] span_us, [63:48] dist_mm,
    // [71:64] confidence
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,   // [0] range_valid, [1] flow_good
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       min_conf_w;
    logic [7:0] min_confidence;
    logic       beat;
    logic       res_valid;
    t_result    res;
    t_result    m_res;

    frp_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_min_confidence (min_confidence)
    );

    assign min_conf_w = 1'b0;
    assign beat       = s_axis_tvalid && s_axis_tready && !min_conf_w;

    frp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_beat           (beat),
        .i_byte           (s_axis_tdata),
        .i_min_confidence (min_confidence),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    frp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_m_tready  (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_res     (m_res)
    );

    assign m_axis_tdata = {m_res.confidence, m_res.dist_mm, m_res.span_us,
                           m_res.flow_y, m_res.flow_x};
    assign m_axis_tuser = {m_res.flow_good, m_res.range_valid};

endmodule

// ----- bench/tb_top.sv -----
module tb_top
    import frp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_GAP_MAX = 18;
    localparam int TAIL_CYCLES   = 8;
    localparam int DRAIN_LIMIT   = 5000;

    // Tracks the sensor byte stream and keeps the readings the block owes.
    class t_frame_tracker;
        t_phase          phase;
        int              index;
        logic [7:0]      sum;
        logic [7:0]      check;
        logic [9:0][7:0] body;
        logic [7:0]      min_conf;
        t_result         readings_due[$];
        int              failures;

        function new();
            phase    = PH_WAIT1;
            index    = 0;
            sum      = '0;
            check    = '0;
            body     = '0;
            min_conf = CONF_DEFAULT;
            failures = 0;
        endfunction

        function void set_threshold(logic [7:0] value);
            min_conf = value;
        endfunction

        function void note_fail(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function t_result decode_frame();
            t_result r;
            logic    ok;
            ok            = body[OFS_CONF] >= min_conf;
            r.flow_x      = ok ? {body[OFS_FLOW_X + 1], body[OFS_FLOW_X]} : '0;
            r.flow_y      = ok ? {body[OFS_FLOW_Y + 1], body[OFS_FLOW_Y]} : '0;
            r.span_us     = {body[OFS_SPAN + 1], body[OFS_SPAN]};
            r.dist_mm     = {body[OFS_DISTANCE + 1], body[OFS_DISTANCE]};
            r.confidence  = body[OFS_CONF];
            r.range_valid = ok;
            r.flow_good   = ok && (body[OFS_VALID] == FLOW_OK_MARK);
            return r;
        endfunction

        // Advance the frame state by one accepted byte.
        function void take_byte(logic [7:0] b);
            case (phase)
                PH_WAIT2: begin
                    if (b == HDR_SECOND) begin
                        phase = PH_DATA;
                        index = 0;
                        sum   = '0;
                    end else begin
                        phase = PH_WAIT1;
                    end
                end
                PH_DATA: begin
                    body[index] = b;
                    sum ^= b;
                    index++;
                    if (index >= PAYLOAD_LEN) begin
                        phase = PH_CHECK;
                        index = 0;
                    end
                end
                PH_CHECK: begin
                    check = b;
                    phase = PH_END;
                end
                PH_END: begin
                    if (b == END_MARK && check == sum) begin
                        readings_due.push_back(decode_frame());
                    end
                    phase = PH_WAIT1;
                end
                default: begin
                    phase = (b == HDR_FIRST) ? PH_WAIT2 : PH_WAIT1;
                end
            endcase
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                note_fail($sformatf("mismatch on %s: expected %h, got %h", field, want, got));
            end
        endfunction

        function void check_reading(logic [TDATA_W-1:0] tdata, logic [TUSER_W-1:0] tuser);
            t_result got;
            t_result want;
            // tuser {flow_good, range_valid} sits directly above tdata in the record
            got = {tuser, tdata};
            if (readings_due.size() == 0) begin
                note_fail($sformatf("unexpected reading: %h %h", tuser, tdata));
                return;
            end
            want = readings_due.pop_front();
            cmp("flow_x", want.flow_x, got.flow_x);
            cmp("flow_y", want.flow_y, got.flow_y);
            cmp("span_us", want.span_us, got.span_us);
            cmp("dist_mm", want.dist_mm, got.dist_mm);
            cmp("confidence", 16'(want.confidence), 16'(got.confidence));
            cmp("range_valid", 16'(want.range_valid), 16'(got.range_valid));
            cmp("flow_good", 16'(want.flow_good), 16'(got.flow_good));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [15:0] flow_x, [31:16] flow_y, [47:32] span_us, [63:48] dist_mm,
    // [71:64] confidence
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;         // [0] range_valid, [1] flow_good
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [1:0]           paddr         = '0;
    logic [31:0]          pwdata        = '0;
    logic [31:0]          prdata;
    logic                 pready;

    t_frame_tracker tracker = new();

    int bytes_sent   = 0;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;

    flow_range_frame_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: check each beat and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_reading(m_axis_tdata, m_axis_tuser);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
            stall_left = $urandom_range(FRAME_GAP_MAX, 1) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Called just after a rising edge; returns at the edge that took the beat.
    task automatic push_byte(input logic [7:0] b);
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(FRAME_GAP_MAX, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [9:0][7:0] body, input logic [7:0] check_flip,
                              input logic [7:0] end_byte);
        logic [7:0] sum;
        sum = '0;
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            push_byte(body[i]);
            sum ^= body[i];
        end
        push_byte(sum ^ check_flip);
        push_byte(end_byte);
    endtask

    // Hold off until the block owes nothing, then let it settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.readings_due.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        // upper bits are junk on purpose; only the low byte is kept
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_threshold(value);
    endtask

    task automatic send_random_frame();
        logic [9:0][7:0] body;
        logic [7:0]      thr;
        logic [7:0]      b;
        int              pick;
        thr = tracker.min_conf;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            body[i] = 8'($urandom_range(255));
        end
        if ($urandom_range(3) == 0) begin
            {body[OFS_FLOW_X + 1], body[OFS_FLOW_X]} = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            {body[OFS_FLOW_Y + 1], body[OFS_FLOW_Y]} = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        if ($urandom_range(1)) begin
            body[OFS_VALID] = FLOW_OK_MARK;
        end
        case ($urandom_range(5))
            0:       body[OFS_CONF] = thr;
            1:       body[OFS_CONF] = thr - 8'd1;
            2:       body[OFS_CONF] = thr + 8'd1;
            3:       body[OFS_CONF] = 8'h00;
            4:       body[OFS_CONF] = 8'hFF;
            default: ;
        endcase
        pick = $urandom_range(99);
        if (pick < 72) begin
            send_frame(body, 8'h00, END_MARK);
        end else if (pick < 82) begin
            send_frame(body, 8'($urandom_range(255, 1)), END_MARK);
        end else if (pick < 90) begin
            b = 8'($urandom_range(255));
            if (b == END_MARK) begin
                b ^= 8'h01;
            end
            send_frame(body, 8'h00, b);
        end else if (pick < 95) begin
            b = $urandom_range(1) ? HDR_FIRST : 8'($urandom_range(255));
            if (b == HDR_SECOND) begin
                b ^= 8'h80;
            end
            push_byte(HDR_FIRST);
            push_byte(b);
        end else begin
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [7:0] thr_plan [5];
        int         limit;
        int         waited;
        thr_plan[0] = CONF_DEFAULT;
        thr_plan[1] = 8'h00;
        thr_plan[2] = 8'hFF;
        thr_plan[3] = 8'($urandom_range(255));
        thr_plan[4] = 8'($urandom_range(254, 1));

        repeat (3) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        tx_gap_pct   = 15;
        rx_stall_pct = 15;
        @(posedge i_clk);

        // broken second header byte, FE included, then a stray 0A
        push_byte(HDR_FIRST);
        push_byte(HDR_FIRST);
        push_byte(HDR_SECOND);
        // extremes, confidence right at the reset threshold
        send_frame(80'h32F50000FFFF7FFF8000, 8'h00, END_MARK);
        // other extremes, confidence one below threshold
        send_frame(80'h3100FFFF000080007FFF, 8'h00, END_MARK);

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                wait_drained();
                write_threshold(thr_plan[p]);
            end
            if (p == 4) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (p > 0) begin
                tx_gap_pct   = $urandom_range(2) * 12;
                rx_stall_pct = $urandom_range(2) * 12;
            end
            limit = 31 + (p + 1) * 254;
            while (bytes_sent < limit) send_random_frame();
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (tracker.readings_due.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.readings_due.size() > 0) begin
            tracker.note_fail($sformatf("%0d readings never arrived",
                                        tracker.readings_due.size()));
        end
        if (tracker.failures == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
